// ----- design/euler_trs_model_matrix_macros.svh -----
// Assertion macros used by the verification checker of the model matrix block
`ifndef EULER_TRS_MODEL_MATRIX_MACROS_SVH
`define EULER_TRS_MODEL_MATRIX_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ETMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etmm check failed");

// Next-cycle implication, disabled while reset is low
`define ETMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etmm check failed");

`endif

// ----- design/etmm_pkg.sv -----
// Types, constants and elaboration helpers for the model matrix block
`default_nettype none
package etmm_pkg;

  localparam int unsigned ZW = 42;
  localparam int unsigned XW = 34;
  localparam logic signed [XW-1:0] INV_GAIN = 34'sh026DD3B6A;
  localparam logic [63:0] RAD_IN_DEG = 64'd246083499208;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               saturated;
    logic               last_row;
  } out_t;

  // atan(2^-i) in degrees with 32 fraction bits; evaluated at elaboration only
  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned sh;
    sum = '0;
    if (i == 0) begin
      sum = 64'd45 << 32;
    end else begin
      for (int unsigned n = 0; n < 32; n++) begin
        sh = (2 * n + 1) * i;
        if (sh < 64) begin
          term = (RAD_IN_DEG >> sh) / 64'(2 * n + 1);
          if (n[0]) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return ZW'(sum);
  endfunction

endpackage
`default_nettype wire

// ----- design/etmm_sincos.sv -----
// Pipelined angle reduction and CORDIC sine/cosine for one angle
`default_nettype none
module etmm_sincos #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] angle,
  output logic signed [31:0] sin_q,
  output logic signed [31:0] cos_q
);

  localparam int unsigned ZW = etmm_pkg::ZW;
  localparam int unsigned XW = etmm_pkg::XW;
  localparam longint unsigned FULL  = 64'd360 << FRAC_BITS;
  localparam longint unsigned NOFF  = (64'd2147483648 + FULL - 64'd1) / FULL;
  localparam longint unsigned OFFS  = NOFF * FULL;
  localparam int unsigned UW = 35;
  localparam int unsigned RS = 35;
  localparam longint unsigned RECIP = (64'd1 << RS) / FULL;
  localparam int unsigned RW = $clog2(RECIP + 1);
  localparam logic signed [ZW-1:0] D90  = ZW'(64'd90 << 32);
  localparam logic signed [ZW-1:0] D180 = ZW'(64'd180 << 32);
  localparam logic signed [ZW-1:0] D270 = ZW'(64'd270 << 32);
  localparam logic signed [ZW-1:0] D360 = ZW'(64'd360 << 32);

  logic [UW-1:0]    u_r, u1_r, r1_r;
  logic [UW+RW-1:0] p_r;
  logic [RW-1:0]    q;
  logic [UW-1:0]    r;
  logic signed [ZW-1:0] z0_r, zz;

  logic signed [XW-1:0] cx_r [0:CORDIC_STEPS];
  logic signed [XW-1:0] cy_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz_r [0:CORDIC_STEPS];
  logic                 fl_r [0:CORDIC_STEPS];

  assign q  = p_r[UW+RW-1:RS];
  assign r  = (r1_r >= UW'(FULL)) ? (r1_r - UW'(FULL)) : r1_r;
  assign zz = ZW'(r);

  // lift into a non-negative range, then divide by 360 degrees via reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= UW'($signed({{(UW-32){angle[31]}}, angle})) + UW'(OFFS);
      p_r  <= (UW+RW)'(u_r) * (UW+RW)'(RECIP);
      u1_r <= u_r;
      r1_r <= UW'(u1_r - UW'(64'(q) * FULL));
      z0_r <= zz << (32 - FRAC_BITS);
    end
  end

  // fold into [-90,90]; crossing the half turn negates sine and cosine
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= etmm_pkg::INV_GAIN;
      cy_r[0] <= '0;
      if (z0_r <= D90) begin
        cz_r[0] <= z0_r;
        fl_r[0] <= 1'b0;
      end else if (z0_r < D270) begin
        cz_r[0] <= z0_r - D180;
        fl_r[0] <= 1'b1;
      end else begin
        cz_r[0] <= z0_r - D360;
        fl_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = etmm_pkg::atan_deg(i);
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[i+1] <= fl_r[i];
        if (!cz_r[i][ZW-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - ATAN;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= 32'(fl_r[CORDIC_STEPS] ? -cx_r[CORDIC_STEPS] : cx_r[CORDIC_STEPS]);
      sin_q <= 32'(fl_r[CORDIC_STEPS] ? -cy_r[CORDIC_STEPS] : cy_r[CORDIC_STEPS]);
    end
  end

endmodule
`default_nettype wire

// ----- design/euler_trs_model_matrix.sv -----
// Top level: pose in, four rows of the TRS model matrix out
`default_nettype none
// Pose to model matrix M = T * Rx * Ry * Rz * S. Each accepted item is a pose
// (position, Euler angles in degrees, per-axis scale, all signed fixed point
// with FRAC_BITS fraction bits); it leaves as four row items, rows 0 to 3 in
// order, last_row marking row 3. The output serialiser holds a finished
// matrix for four row transfers, and the pipeline behind it moves only when
// the serialiser can load or the last pipeline stage is empty. Every stage
// advances together; a stall freezes the whole pipeline, so nothing is lost
// or repeated. Elements are rounded half up and saturated; saturated flags a
// clipped row. Row 3 is 0,0,0,1.
module euler_trs_model_matrix #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  etmm_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output etmm_pkg::out_t   out_data
);

  // sincos depth, then five stages of products, sums, scaling and clipping
  localparam int LAT_SC  = CORDIC_STEPS + 6;
  localparam int LAT_TOT = LAT_SC + 5;
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [65:0] RND  = 66'sd536870912;
  localparam logic signed [65:0] SMAX = 66'sd2147483647;
  localparam logic signed [65:0] SMIN = -66'sd2147483648;

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 32'(p >>> 30);
  endfunction

  logic adv, take;
  logic vld_r [0:LAT_TOT-1];
  etmm_pkg::in_t side_r [0:LAT_TOT-1];

  logic signed [31:0] sx, cx, sy, cy, sz, cz;

  // take a new matrix when the serialiser is empty or its last row leaves
  assign take     = !out_valid || (out_ready && (out_data.row_index == 2'd3));
  assign adv      = !vld_r[LAT_TOT-1] || take;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT_TOT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT_TOT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // carry position and scale alongside the angle work
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_data;
      for (int k = 1; k < LAT_TOT; k++) side_r[k] <= side_r[k-1];
    end
  end

  etmm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (
    .clk(clk), .en(adv), .angle(in_data.angle_x), .sin_q(sx), .cos_q(cx));
  etmm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (
    .clk(clk), .en(adv), .angle(in_data.angle_y), .sin_q(sy), .cos_q(cy));
  etmm_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (
    .clk(clk), .en(adv), .angle(in_data.angle_z), .sin_q(sz), .cos_q(cz));

  // first products
  logic signed [31:0] cycz_r, cysz_r, sxsy_r, cxsz_r, cxcz_r, sxcy_r;
  logic signed [31:0] cxsy_r, sxsz_r, sxcz_r, cxcy_r, sy1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cycz_r <= qmul(cy, cz);
      cysz_r <= qmul(cy, sz);
      sxsy_r <= qmul(sx, sy);
      cxsz_r <= qmul(cx, sz);
      cxcz_r <= qmul(cx, cz);
      sxcy_r <= qmul(sx, cy);
      cxsy_r <= qmul(cx, sy);
      sxsz_r <= qmul(sx, sz);
      sxcz_r <= qmul(sx, cz);
      cxcy_r <= qmul(cx, cy);
      sy1_r  <= sy;
    end
  end

  // hold the z sine and cosine one stage for the three-factor terms
  logic signed [31:0] cz_d1, sz_d1;
  always_ff @(posedge clk) begin
    if (adv) begin
      cz_d1 <= cz;
      sz_d1 <= sz;
    end
  end

  // three-factor terms; hold the rest one stage
  logic signed [31:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [31:0] cycz2_r, cysz2_r, sy2_r, cxsz2_r, cxcz2_r, sxcy2_r;
  logic signed [31:0] sxsz2_r, sxcz2_r, cxcy2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r    <= qmul(sxsy_r, cz_d1);
      t2_r    <= qmul(sxsy_r, sz_d1);
      t3_r    <= qmul(cxsy_r, cz_d1);
      t4_r    <= qmul(cxsy_r, sz_d1);
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      sy2_r   <= sy1_r;
      cxsz2_r <= cxsz_r;
      cxcz2_r <= cxcz_r;
      sxcy2_r <= sxcy_r;
      sxsz2_r <= sxsz_r;
      sxcz2_r <= sxcz_r;
      cxcy2_r <= cxcy_r;
    end
  end

  // sums: the rotation matrix in Q4.30
  logic signed [33:0] m_r [0:2][0:2];
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r[0][0] <= 34'(cycz2_r);
      m_r[0][1] <= -34'(cysz2_r);
      m_r[0][2] <= 34'(sy2_r);
      m_r[1][0] <= 34'(t1_r) + 34'(cxsz2_r);
      m_r[1][1] <= 34'(cxcz2_r) - 34'(t2_r);
      m_r[1][2] <= -34'(sxcy2_r);
      m_r[2][0] <= 34'(sxsz2_r) - 34'(t3_r);
      m_r[2][1] <= 34'(t4_r) + 34'(sxcz2_r);
      m_r[2][2] <= 34'(cxcy2_r);
    end
  end

  // column scaling with the rounding bias
  logic signed [31:0] scl [0:2];
  logic signed [65:0] prod_r [0:2][0:2];
  assign scl[0] = side_r[LAT_SC+2].scale_x;
  assign scl[1] = side_r[LAT_SC+2].scale_y;
  assign scl[2] = side_r[LAT_SC+2].scale_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= 66'(m_r[i][j]) * 66'(scl[j]) + RND;
        end
      end
    end
  end

  // drop the fraction and clip to 32 bits
  logic signed [65:0] shv [0:2][0:2];
  logic               ovf [0:2][0:2];
  logic               unf [0:2][0:2];
  logic signed [31:0] el_r [0:2][0:2];
  logic               clp_r [0:2];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) shv[i][j] = prod_r[i][j] >>> 30;
    end
  end
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ovf[i][j] = shv[i][j] > SMAX;
        unf[i][j] = shv[i][j] < SMIN;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        clp_r[i] <= ovf[i][0] || ovf[i][1] || ovf[i][2] ||
                    unf[i][0] || unf[i][1] || unf[i][2];
        for (int j = 0; j < 3; j++) begin
          if (ovf[i][j]) begin
            el_r[i][j] <= 32'(SMAX);
          end else if (unf[i][j]) begin
            el_r[i][j] <= 32'(SMIN);
          end else begin
            el_r[i][j] <= 32'(shv[i][j]);
          end
        end
      end
    end
  end

  // output serialiser: hold one matrix, send rows 0 to 3
  logic               ser_vld_r;
  logic [1:0]         row_r;
  logic signed [31:0] oel_r [0:2][0:2];
  logic               oclp_r [0:2];
  logic signed [31:0] opos_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      row_r     <= 2'd0;
    end else if (take) begin
      ser_vld_r <= vld_r[LAT_TOT-1];
      row_r     <= 2'd0;
    end else if (out_ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oel_r     <= el_r;
      oclp_r    <= clp_r;
      opos_r[0] <= side_r[LAT_TOT-1].pos_x;
      opos_r[1] <= side_r[LAT_TOT-1].pos_y;
      opos_r[2] <= side_r[LAT_TOT-1].pos_z;
    end
  end

  assign out_valid = ser_vld_r;

  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = 1'b0;
    case (row_r)
      2'd0: begin
        out_data.col0 = oel_r[0][0];
        out_data.col1 = oel_r[0][1];
        out_data.col2 = oel_r[0][2];
        out_data.col3 = opos_r[0];
        out_data.saturated = oclp_r[0];
      end
      2'd1: begin
        out_data.col0 = oel_r[1][0];
        out_data.col1 = oel_r[1][1];
        out_data.col2 = oel_r[1][2];
        out_data.col3 = opos_r[1];
        out_data.saturated = oclp_r[1];
      end
      2'd2: begin
        out_data.col0 = oel_r[2][0];
        out_data.col1 = oel_r[2][1];
        out_data.col2 = oel_r[2][2];
        out_data.col3 = opos_r[2];
        out_data.saturated = oclp_r[2];
      end
      default: begin
        out_data.col0 = '0;
        out_data.col1 = '0;
        out_data.col2 = '0;
        out_data.col3 = ONE;
        out_data.saturated = 1'b0;
        out_data.last_row  = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/etmm_chk.sv -----
// Port-level checker for the model matrix block, bound to the top level
`default_nettype none
`include "euler_trs_model_matrix_macros.svh"
module etmm_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire etmm_pkg::out_t out_data
);

  `ETMM_ASSERT_NEXT(a_rows_follow, out_valid && out_ready && !out_data.last_row, out_valid)
  `ETMM_ASSERT_NEXT(a_row_step, out_valid && out_ready && !out_data.last_row, out_data.row_index == 2'($past(out_data.row_index) + 2'd1))
  `ETMM_ASSERT_NOW(a_bottom_row, out_valid && out_data.last_row, (out_data.col0 == 32'sd0) && (out_data.col1 == 32'sd0) && (out_data.col2 == 32'sd0) && !out_data.saturated && (out_data.row_index == 2'd3))
  `ETMM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind euler_trs_model_matrix etmm_chk u_etmm_chk (.*);
`default_nettype wire
